// ===== design/scfla_pkg.sv =====
// ----------------------------------------------------------------------------
// scfla_pkg
// Shared constants and the size-class function for the size-class free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package scfla_pkg;
  localparam int FREE_ENTRIES = 32;
  localparam int USED_ENTRIES = 32;
  localparam int ADDR_BITS    = 20;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ZERO     = 3'd1;
  localparam logic [2:0] ST_OOM      = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_TOOLARGE = 3'd5;

  localparam logic CFG_FIT_MODE   = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  function automatic logic [9:0] class_of(input logic [11:0] n);
    if (n <= 12'd32)       class_of = 10'd32;
    else if (n <= 12'd64)  class_of = 10'd64;
    else if (n <= 12'd128) class_of = 10'd128;
    else if (n <= 12'd256) class_of = 10'd256;
    else                   class_of = 10'd512;
  endfunction
endpackage
`default_nettype wire

// ===== design/scfla_ram.sv =====
// ----------------------------------------------------------------------------
// scfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module scfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/size_class_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_top
// Size-class allocator: free table and used table in RAM, scanned one entry
// per cycle by a sequencer.
// ----------------------------------------------------------------------------
// channel  | dir | handshake           | payload
// in       | in  | in_valid/in_stall   | req_type, request_bytes, free_address
// out      | out | out_valid/out_stall | address, granted_bytes, from_heap, status
// cfg      | in  | cfg_we              | cfg_index, cfg_data
// An allocate scans the free table one entry a cycle, and an exact-fit removal
// shifts later entries down, each through a read state and a write state.
// A free scans the used table, one entry a cycle.
// Trivial errors skip the scans. Reset is synchronous; no clearing pass.
// The result waits in an output register; a new item is taken once it drains.
// ----------------------------------------------------------------------------
`default_nettype none
module size_class_free_list_allocator_top #(
  parameter int FREE_ENTRIES = scfla_pkg::FREE_ENTRIES,
  parameter int USED_ENTRIES = scfla_pkg::USED_ENTRIES
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         req_type,
  input  wire  [11:0] request_bytes,
  input  wire  [19:0] free_address,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [19:0] address,
  output logic [9:0]  granted_bytes,
  output logic        from_heap,
  output logic [2:0]  status,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [20:0] cfg_data
);
  localparam int ADDR_BITS = scfla_pkg::ADDR_BITS;
  localparam int FW = $clog2(FREE_ENTRIES);
  localparam int UW = $clog2(USED_ENTRIES);
  localparam int CW = $clog2(FREE_ENTRIES + 1);
  localparam int UCW = $clog2(USED_ENTRIES + 1);
  localparam int BW = ADDR_BITS + 1;
  localparam logic [BW-1:0] ADDR_SPAN = BW'(1) << ADDR_BITS;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FSCAN = 7'b0000010,
    S_FDEC  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_SHWR  = 7'b0010000,
    S_USCAN = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic fit_mode;
  logic [20:0] heap_limit;
  logic [CW-1:0] free_count;
  logic [BW-1:0] heap_break;
  logic [USED_ENTRIES-1:0] used_valid;

  logic [9:0] cls;
  logic [ADDR_BITS-1:0] req_addr;
  logic [UW-1:0] slot;
  logic [CW-1:0] idx;
  logic [UCW-1:0] uidx;
  logic found;
  logic [FW-1:0] pick;
  logic [9:0] pick_bytes;
  logic [ADDR_BITS-1:0] pick_base;

  // free table RAM {base, bytes}
  logic f_we;
  logic [FW-1:0] f_waddr, f_raddr;
  logic [ADDR_BITS+9:0] f_wdata, f_rdata;
  scfla_ram #(.WIDTH(ADDR_BITS + 10), .DEPTH(FREE_ENTRIES)) u_free (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata));

  logic u_we;
  logic [UW-1:0] u_waddr, u_raddr;
  logic [ADDR_BITS+9:0] u_wdata, u_rdata;
  scfla_ram #(.WIDTH(ADDR_BITS + 10), .DEPTH(USED_ENTRIES)) u_used (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata));

  logic [ADDR_BITS-1:0] f_rbase;
  logic [9:0] f_rbytes;
  assign f_rbase  = f_rdata[ADDR_BITS+9:10];
  assign f_rbytes = f_rdata[9:0];

  // lowest invalid used slot
  logic have_slot;
  logic [UW-1:0] free_slot;
  always_comb begin
    have_slot = 1'b0;
    free_slot = '0;
    for (int i = USED_ENTRIES - 1; i >= 0; i--) begin
      if (!used_valid[i]) begin
        have_slot = 1'b1;
        free_slot = UW'(i);
      end
    end
  end

  logic [BW-1:0] eff_limit;
  assign eff_limit = (BW'(heap_limit) > ADDR_SPAN) ? ADDR_SPAN : BW'(heap_limit);

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // read address: scanning index or shift source
  always_comb begin
    f_raddr = idx[FW-1:0];
    if (accept) f_raddr = '0;
    u_raddr = uidx[UW-1:0];
    if (accept) u_raddr = '0;
  end

  // a read issued last cycle is present now; ridx and ruidx name its entry
  logic [CW-1:0] ridx;
  logic [UCW-1:0] ruidx;
  logic fit_hit;
  assign fit_hit = (f_rbytes >= cls) && (!found || (fit_mode && f_rbytes < pick_bytes));

  always_comb begin
    f_we = 1'b0;
    f_waddr = pick;
    f_wdata = {pick_base, pick_bytes};
    u_we = 1'b0;
    u_waddr = slot;
    u_wdata = {pick_base, cls};
    unique case (state)
      S_FDEC: begin
        if (found && pick_bytes != cls) begin
          f_we = 1'b1;
          f_wdata = {pick_base + ADDR_BITS'(cls), pick_bytes - cls};
        end
        if (found || (heap_break + BW'(cls) <= eff_limit)) begin
          u_we = 1'b1;
          u_wdata = {found ? pick_base : heap_break[ADDR_BITS-1:0], cls};
        end
      end
      S_SHWR: begin
        f_we = 1'b1;
        f_waddr = FW'(ridx - CW'(1));
        f_wdata = f_rdata;
      end
      S_USCAN: begin
        // u_rdata holds entry ruidx
        if (used_valid[UW'(ruidx)] && u_rdata[ADDR_BITS+9:10] == req_addr
            && free_count < CW'(FREE_ENTRIES)) begin
          f_we = 1'b1;
          f_waddr = FW'(free_count);
          f_wdata = u_rdata;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fit_mode <= 1'b0;
      heap_limit <= 21'd1048576;
      free_count <= '0;
      heap_break <= '0;
      used_valid <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == scfla_pkg::CFG_FIT_MODE) fit_mode <= cfg_data[0];
        else heap_limit <= cfg_data;
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          cls <= scfla_pkg::class_of(request_bytes);
          req_addr <= free_address[ADDR_BITS-1:0];
          slot <= free_slot;
          found <= 1'b0;
          address <= '0; granted_bytes <= '0; from_heap <= 1'b0;
          idx <= CW'(1); ridx <= '0;
          uidx <= UCW'(1); ruidx <= '0;
          if (req_type) state <= S_USCAN;
          else if (request_bytes == 12'd0) begin
            status <= scfla_pkg::ST_ZERO; state <= S_OUT;
          end else if (request_bytes > 12'd512) begin
            status <= scfla_pkg::ST_TOOLARGE; state <= S_OUT;
          end else if (!have_slot) begin
            status <= scfla_pkg::ST_FULL; state <= S_OUT;
          end else state <= (free_count == '0) ? S_FDEC : S_FSCAN;
        end
        S_FSCAN: begin
          // f_rdata holds entry ridx
          if (fit_hit) begin
            found <= 1'b1; pick <= FW'(ridx);
            pick_bytes <= f_rbytes; pick_base <= f_rbase;
          end
          if ((fit_hit && !fit_mode) || (found && !fit_mode) || ridx + CW'(1) >= free_count)
            state <= S_FDEC;
          ridx <= ridx + CW'(1);
          if (idx < CW'(FREE_ENTRIES - 1)) idx <= idx + CW'(1);
        end
        S_FDEC: begin
          status <= scfla_pkg::ST_OK;
          state <= S_OUT;
          if (found) begin
            address <= pick_base; granted_bytes <= cls;
            used_valid[slot] <= 1'b1;
            if (pick_bytes == cls) begin
              if (32'(pick) + 1 < 32'(free_count)) begin
                idx <= CW'(pick) + CW'(1);
                state <= S_SHIFT;
              end else free_count <= free_count - CW'(1);
            end
          end else if (heap_break + BW'(cls) <= eff_limit) begin
            address <= heap_break[ADDR_BITS-1:0]; granted_bytes <= cls; from_heap <= 1'b1;
            heap_break <= heap_break + BW'(cls);
            used_valid[slot] <= 1'b1;
          end else status <= scfla_pkg::ST_OOM;
        end
        S_SHIFT: begin
          // issue read of idx, data next cycle
          ridx <= idx;
          state <= S_SHWR;
        end
        S_SHWR: begin
          if (ridx + CW'(1) < free_count) begin
            idx <= ridx + CW'(1);
            state <= S_SHIFT;
          end else begin
            free_count <= free_count - CW'(1);
            state <= S_OUT;
          end
        end
        S_USCAN: begin
          if (used_valid[UW'(ruidx)] && u_rdata[ADDR_BITS+9:10] == req_addr) begin
            state <= S_OUT;
            if (free_count < CW'(FREE_ENTRIES)) begin
              status <= scfla_pkg::ST_OK;
              address <= req_addr; granted_bytes <= u_rdata[9:0];
              free_count <= free_count + CW'(1);
              used_valid[UW'(ruidx)] <= 1'b0;
            end else status <= scfla_pkg::ST_FULL;
          end else if (ruidx == UCW'(USED_ENTRIES - 1)) begin
            status <= scfla_pkg::ST_UNKNOWN;
            state <= S_OUT;
          end
          ruidx <= ruidx + UCW'(1);
          if (uidx < UCW'(USED_ENTRIES - 1)) uidx <= uidx + UCW'(1);
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/size_class_free_list_allocator_top_test.sv =====
// ----------------------------------------------------------------------------
// size_class_free_list_allocator_top_test
// Checks the allocator against a behavioral model of its free and used tables.
// Each result is compared with the expected one, oldest first, while both
// channels go idle or stall at random. Fit mode and heap limit are changed
// between phases.
// ----------------------------------------------------------------------------
module size_class_free_list_allocator_top_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic [19:0] address;
    logic [9:0]  granted_bytes;
    logic        from_heap;
    logic [2:0]  status;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic [11:0] request_bytes = '0;
  logic [19:0] free_address = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [19:0] address;
  logic [9:0] granted_bytes;
  logic from_heap;
  logic [2:0] status;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [20:0] cfg_data = '0;

  size_class_free_list_allocator_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .request_bytes(request_bytes), .free_address(free_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .address(address), .granted_bytes(granted_bytes), .from_heap(from_heap),
    .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [19:0] fl_base [scfla_pkg::FREE_ENTRIES];
  logic [9:0]  fl_bytes [scfla_pkg::FREE_ENTRIES];
  int          fl_count;
  logic [19:0] ul_base [scfla_pkg::USED_ENTRIES];
  logic [9:0]  ul_bytes [scfla_pkg::USED_ENTRIES];
  logic        ul_valid [scfla_pkg::USED_ENTRIES];
  logic [20:0] brk;
  logic        m_fit_mode;
  logic [20:0] m_heap_limit;

  grant_t expected_grants[$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_req = 0;
  int hold_done = 0;
  int gap_max = 3;

  function automatic logic [9:0] size_class(input logic [11:0] n);
    if (n <= 32) return 10'd32;
    if (n <= 64) return 10'd64;
    if (n <= 128) return 10'd128;
    if (n <= 256) return 10'd256;
    return 10'd512;
  endfunction

  function automatic grant_t predict_alloc(input logic [11:0] req);
    grant_t g;
    logic [9:0] cls;
    int slot, pick;
    bit found;
    logic [21:0] lim;
    g = '0;
    if (req == 0) begin g.status = scfla_pkg::ST_ZERO; return g; end
    if (req > 512) begin g.status = scfla_pkg::ST_TOOLARGE; return g; end
    cls = size_class(req);
    slot = -1;
    for (int i = 0; i < scfla_pkg::USED_ENTRIES; i++)
      if (!ul_valid[i] && slot < 0) slot = i;
    if (slot < 0) begin g.status = scfla_pkg::ST_FULL; return g; end
    found = 0;
    pick = 0;
    for (int i = 0; i < fl_count; i++) begin
      if (fl_bytes[i] >= cls) begin
        if (!m_fit_mode) begin
          if (!found) begin pick = i; found = 1; end
        end else if (!found || fl_bytes[i] < fl_bytes[pick]) begin
          pick = i;
          found = 1;
        end
      end
    end
    if (found) begin
      g.address = fl_base[pick];
      if (fl_bytes[pick] == cls) begin
        for (int i = pick; i + 1 < fl_count; i++) begin
          fl_base[i] = fl_base[i+1];
          fl_bytes[i] = fl_bytes[i+1];
        end
        fl_count--;
      end else begin
        fl_bytes[pick] -= cls;
        fl_base[pick] += cls;
      end
    end else begin
      lim = (m_heap_limit > 21'h100000) ? 22'h100000 : {1'b0, m_heap_limit};
      if ({1'b0, brk} + cls > lim) begin g.status = scfla_pkg::ST_OOM; return g; end
      g.address = brk[19:0];
      g.from_heap = 1'b1;
      brk += cls;
    end
    ul_base[slot] = g.address;
    ul_bytes[slot] = cls;
    ul_valid[slot] = 1'b1;
    g.granted_bytes = cls;
    g.status = scfla_pkg::ST_OK;
    return g;
  endfunction

  function automatic grant_t predict_free(input logic [19:0] a);
    grant_t g;
    g = '0;
    for (int i = 0; i < scfla_pkg::USED_ENTRIES; i++) begin
      if (ul_valid[i] && ul_base[i] == a) begin
        if (fl_count >= scfla_pkg::FREE_ENTRIES) begin
          g.status = scfla_pkg::ST_FULL;
          return g;
        end
        fl_base[fl_count] = ul_base[i];
        fl_bytes[fl_count] = ul_bytes[i];
        fl_count++;
        ul_valid[i] = 1'b0;
        g.address = a;
        g.granted_bytes = ul_bytes[i];
        g.status = scfla_pkg::ST_OK;
        return g;
      end
    end
    g.status = scfla_pkg::ST_UNKNOWN;
    return g;
  endfunction

  // random address of a live chunk, or a random offset if none
  function automatic logic [19:0] live_address();
    int picks[$];
    for (int i = 0; i < scfla_pkg::USED_ENTRIES; i++)
      if (ul_valid[i]) picks = {picks, i};
    if (picks.size() == 0) return 20'($urandom);
    return ul_base[picks[$urandom_range(picks.size()-1)]];
  endfunction

  task automatic send_request(input logic kind, input logic [11:0] nbytes,
                              input logic [19:0] faddr);
    grant_t g;
    int gap;
    gap = 0;
    if (gap_max > 0 && $urandom_range(3) == 0) gap = $urandom_range(1, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    request_bytes <= nbytes;
    free_address <= faddr;
    do @(posedge clk); while (in_stall);
    g = (kind == REQ_ALLOC) ? predict_alloc(nbytes) : predict_free(faddr);
    expected_grants = {expected_grants, g};
    @(negedge clk);
  endtask

  task automatic alloc(input logic [11:0] n);
    send_request(REQ_ALLOC, n, 20'($urandom));
  endtask

  task automatic release_chunk(input logic [19:0] a);
    send_request(REQ_FREE, 12'($urandom), a);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [20:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == scfla_pkg::CFG_FIT_MODE) m_fit_mode = val[0];
    else m_heap_limit = val;
    @(negedge clk);
  endtask

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
        hold_done++;
      end else if (($time / 3000) % 3 == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(2) == 0);
      end
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (!rst && out_valid && !out_stall) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected result addr=%h bytes=%0d heap=%0d status=%0d",
                 $time, address, granted_bytes, from_heap, status);
        errors++;
      end else begin
        g = expected_grants.pop_front();
        if (address !== g.address) begin
          $display("%0t: address expected %h actual %h", $time, g.address, address);
          errors++;
        end
        if (granted_bytes !== g.granted_bytes) begin
          $display("%0t: granted_bytes expected %0d actual %0d",
                   $time, g.granted_bytes, granted_bytes);
          errors++;
        end
        if (from_heap !== g.from_heap) begin
          $display("%0t: from_heap expected %0d actual %0d", $time, g.from_heap, from_heap);
          errors++;
        end
        if (status !== g.status) begin
          $display("%0t: status expected %0d actual %0d", $time, g.status, status);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic test_special_cases();
    alloc(12'd0);
    alloc(12'd513);
    alloc(12'hFFF);
    alloc(12'd1); alloc(12'd32); alloc(12'd33); alloc(12'd64); alloc(12'd65);
    alloc(12'd128); alloc(12'd200); alloc(12'd256); alloc(12'd257); alloc(12'd512);
    release_chunk(20'hFFFFF);      // unknown
    release_chunk(20'd0);
    release_chunk(20'd32);
    alloc(12'd16);                 // exact fit from free table
    alloc(12'd40);                 // from the heap: no free entry is large enough
    release_chunk(live_address());
    drain();
  endtask

  task automatic test_table_limits();
    // fill used table, then table full on allocate
    for (int i = 0; i < 34; i++) alloc(12'd1);
    // free everything: the free table fills
    for (int i = 0; i < scfla_pkg::USED_ENTRIES; i++) release_chunk(live_address());
    drain();
  endtask

  task automatic test_heap_exhaustion();
    write_reg(scfla_pkg::CFG_HEAP_LIMIT, 21'd0);
    alloc(12'd500);                // free table may still serve
    for (int i = 0; i < 6; i++) alloc(12'd512);
    drain();
    write_reg(scfla_pkg::CFG_HEAP_LIMIT, 21'h1FFFFF);   // saturates at the address space
  endtask

  task automatic test_random(input int count, input logic mode);
    write_reg(scfla_pkg::CFG_FIT_MODE, mode);
    for (int i = 0; i < count; i++) begin
      int r;
      r = $urandom_range(99);
      if (r < 45) alloc(12'($urandom_range(1, 512)));
      else if (r < 85) release_chunk(live_address());
      else if (r < 92) alloc(12'($urandom));
      else release_chunk(20'($urandom));
      if (i % 200 == 199) gap_max = $urandom_range(0, 6);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_req++;
    for (int i = 0; i < 20; i++) alloc(12'($urandom_range(1, 512)));
    drain();
  endtask

  initial begin
    fl_count = 0;
    brk = '0;
    m_fit_mode = 1'b0;
    m_heap_limit = 21'h100000;
    for (int i = 0; i < scfla_pkg::USED_ENTRIES; i++) ul_valid[i] = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_special_cases();
    test_table_limits();
    test_heap_exhaustion();
    test_random(500, 1'b0);
    test_backpressure();
    test_random(500, 1'b1);
    write_reg(scfla_pkg::CFG_HEAP_LIMIT, 21'($urandom_range(0, 21'h100000)));
    test_random(450, 1'b0);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
